/* sv/bbc_pkg.sv */
// Shared types and constants for the bracket balance checker.
// Used by bbc_front, bbc_back and bracket_balance_checker; depends on nothing.
package bbc_pkg;

   // Character codes of the six brackets
   localparam logic [7:0] CHAR_OPEN_PAREN   = 8'h28;
   localparam logic [7:0] CHAR_CLOSE_PAREN  = 8'h29;
   localparam logic [7:0] CHAR_OPEN_SQUARE  = 8'h5B;
   localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5D;
   localparam logic [7:0] CHAR_OPEN_CURLY   = 8'h7B;
   localparam logic [7:0] CHAR_CLOSE_CURLY  = 8'h7D;

   // Expected-closer codes held on the stack
   localparam logic [1:0] CODE_PAREN  = 2'd0;
   localparam logic [1:0] CODE_SQUARE = 2'd1;
   localparam logic [1:0] CODE_CURLY  = 2'd2;

   localparam int COUNT_WIDTH = 6;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } bbc_req_type;

   typedef struct packed {
      logic                   correct;
      logic [COUNT_WIDTH-1:0] unclosed_count;
      logic                   stray_close;
      logic                   overflowed;
   } bbc_rsp_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_PUSH,
      OP_POP
   } bbc_op_kind_type;

   typedef struct packed {
      bbc_op_kind_type kind;
      logic [1:0]      code;
      logic            last;
   } bbc_op_type;

   function automatic bbc_op_type bbc_classify(input logic [7:0] character,
                                               input logic last);
      bbc_op_type op;
      op.kind = OP_NONE;
      op.code = CODE_PAREN;
      op.last = last;
      case (character)
         CHAR_OPEN_PAREN: begin
            op.kind = OP_PUSH;
            op.code = CODE_PAREN;
         end
         CHAR_OPEN_SQUARE: begin
            op.kind = OP_PUSH;
            op.code = CODE_SQUARE;
         end
         CHAR_OPEN_CURLY: begin
            op.kind = OP_PUSH;
            op.code = CODE_CURLY;
         end
         CHAR_CLOSE_PAREN: begin
            op.kind = OP_POP;
            op.code = CODE_PAREN;
         end
         CHAR_CLOSE_SQUARE: begin
            op.kind = OP_POP;
            op.code = CODE_SQUARE;
         end
         CHAR_CLOSE_CURLY: begin
            op.kind = OP_POP;
            op.code = CODE_CURLY;
         end
         default: begin
            op.kind = OP_NONE;
         end
      endcase
      return op;
   endfunction

endpackage

/* sv/bbc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bbc_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/bbc_front.sv */
// Front end: accepts characters, classifies them into stack operations and
// queues them in a two-entry buffer. Depends on bbc_pkg.
module bbc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  bbc_pkg::bbc_req_type req_data,
   output logic                op_valid,
   input  logic                op_stall,
   output bbc_pkg::bbc_op_type op_data
);
   import bbc_pkg::*;

   bbc_op_type queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign op_valid  = (count_ff != 2'd0);
   assign pop       = op_valid && !op_stall;
   assign op_data   = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= bbc_classify(req_data.character, req_data.last);
      end
   end

endmodule

/* sv/bbc_back.sv */
// Back end: runs push/pop operations on the expected-closer stack and
// registers the result of each expression. Depends on bbc_pkg and bbc_ram.
module bbc_back #(
   parameter int STACK_DEPTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 op_valid,
   output logic                 op_stall,
   input  bbc_pkg::bbc_op_type  op_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bbc_pkg::bbc_rsp_type rsp_data
);
   import bbc_pkg::*;

   localparam int DW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   // Top two entries live in registers; entries below them live in the RAM.
   logic [DW-1:0] depth_ff, depth_in;
   logic [1:0]    top_ff, top_in;
   logic [1:0]    sec_ff, sec_in;
   logic          stray_ff, stray_in;
   logic          ovf_ff, ovf_in;
   logic          byp_ff, byp_in;
   logic [1:0]    byp_data_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   bbc_rsp_type   rsp_data_ff, rsp_data_in;

   logic          take;
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [DW-1:0] depth_m2, depth_m3;
   logic [1:0]    rd_data, mem_out;

   assign op_stall  = rsp_valid_ff && rsp_stall;
   assign take      = op_valid && !op_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign mem_out   = byp_ff ? byp_data_ff : rd_data;
   assign depth_m2  = depth_ff - DW'(2);

   always_comb begin
      depth_in     = depth_ff;
      top_in       = top_ff;
      sec_in       = sec_ff;
      stray_in     = stray_ff;
      ovf_in       = ovf_ff;
      wr_en        = 1'b0;
      wr_addr      = depth_m2[AW-1:0];
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (take) begin
         case (op_data.kind)
            OP_PUSH: begin
               if (depth_ff == DW'(STACK_DEPTH)) begin
                  ovf_in = 1'b1;
               end else begin
                  top_in   = op_data.code;
                  sec_in   = top_ff;
                  depth_in = depth_ff + DW'(1);
                  // spill the old second entry below the registered pair
                  wr_en    = (depth_ff >= DW'(2));
               end
            end
            OP_POP: begin
               if (depth_ff == '0) begin
                  stray_in = 1'b1;
               end else if (top_ff == op_data.code) begin
                  depth_in = depth_ff - DW'(1);
                  top_in   = sec_ff;
                  sec_in   = mem_out;
               end
            end
            default: begin
               depth_in = depth_ff;
            end
         endcase
         if (op_data.last) begin
            rsp_valid_in               = 1'b1;
            rsp_data_in.correct        = (depth_in == '0) && !stray_in && !ovf_in;
            rsp_data_in.unclosed_count = COUNT_WIDTH'(depth_in);
            rsp_data_in.stray_close    = stray_in;
            rsp_data_in.overflowed     = ovf_in;
            depth_in = '0;
            stray_in = 1'b0;
            ovf_in   = 1'b0;
         end
      end
   end

   // Prefetch the entry that becomes second after a pop
   always_comb begin
      depth_m3 = depth_in - DW'(3);
      rd_addr  = (depth_in >= DW'(3)) ? depth_m3[AW-1:0] : '0;
      byp_in   = wr_en && (wr_addr == rd_addr);
   end

   bbc_ram #(
      .WIDTH(2),
      .DEPTH(STACK_DEPTH)
   ) u_stack_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(sec_ff),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         stray_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
         byp_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         depth_ff     <= depth_in;
         stray_ff     <= stray_in;
         ovf_ff       <= ovf_in;
         byp_ff       <= byp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff      <= top_in;
      sec_ff      <= sec_in;
      byp_data_ff <= sec_ff;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* sv/bracket_balance_checker.sv */
// Bracket balance checker top level: front classifier and queue, back stack engine.
// Depends on bbc_pkg, bbc_front, bbc_back and bbc_ram.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | bbc_req_type: character, last
//   rsp     | out       | rsp_valid / rsp_stall | bbc_rsp_type: correct, unclosed_count,
//           |           |                       |   stray_close, overflowed
//
// One character per cycle sustained; the back end does one push or pop a cycle
// with the top two stack entries in registers and a prefetch read of the RAM.
// A final character is queued, then its result is registered at the output.
// Synchronous reset empties the queue, the stack and the output register.
// A stalled result holds the back end; the two-entry queue then fills and
// raises req_stall.
module bracket_balance_checker #(
   parameter int STACK_DEPTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  bbc_pkg::bbc_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bbc_pkg::bbc_rsp_type rsp_data
);
   import bbc_pkg::*;

   logic       op_valid;
   logic       op_stall;
   bbc_op_type op_data;

   bbc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .op_valid (op_valid),
      .op_stall (op_stall),
      .op_data  (op_data)
   );

   bbc_back #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .op_valid (op_valid),
      .op_stall (op_stall),
      .op_data  (op_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall && !op_valid)
      else $error("state not cleared by reset");

   a_correct_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.correct |->
         rsp_data.unclosed_count == '0 && !rsp_data.stray_close && !rsp_data.overflowed)
      else $error("correct flag contradicts status fields");

   a_full_has_head: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> op_valid)
      else $error("queue full with no head entry");

   a_back_stall_source: assert property (@(posedge clock) disable iff (reset)
      op_stall |-> rsp_valid && rsp_stall)
      else $error("back end stalled without a stalled result");

endmodule
